// ===== hdl/tcw_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the text console writer.
package tcw_pkg;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int COPY_COUNT    = SCREEN_WIDTH * (SCREEN_HEIGHT - 1);

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
  localparam int COL_W  = $clog2(SCREEN_WIDTH);

  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int INDEX_W    = 11;
  localparam int POS_W      = 11;
  localparam int ATTR_W     = 8;
  localparam int COLOR_W    = 4;
  localparam int CELL_W     = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'h20;
  localparam logic [CELL_W-1:0]  RESET_CELL   = 16'h0F20;
  localparam logic [COLOR_W-1:0] FG_RESET     = 4'hF;
  localparam logic [COLOR_W-1:0] BG_RESET     = 4'h0;

  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 8'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_BS    = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    SW_RESET  = 2'd0,
    SW_CLEAR  = 2'd1,
    SW_SCROLL = 2'd2
  } sweep_kind_e;

  typedef struct packed {
    logic        put_wr;
    logic        new_line;
    logic        back_space;
    logic        home;
    logic        sweep_en;
    sweep_kind_e sweep_kind;
    logic        rd_capture;
    logic        res_load;
    logic        res_rd;
  } dp_cmd_t;

  typedef struct packed {
    logic col_last;
    logic row_last;
    logic at_origin;
    logic sweep_last;
    logic out_valid;
  } dp_stat_t;

endpackage

// ===== hdl/text_console_writer_core.sv =====
// Top level of the text console writer: stream ports, config port, controller and datapath.
//
// Text console of SCREEN_WIDTH x SCREEN_HEIGHT character cells kept in one on-chip memory with a
// single write port and a single registered read port. Put char, newline, backspace and read cell
// go through the DONE or READ state before their result is loaded. Clear, and a put or newline that
// scrolls, sweep the whole memory one cell per cycle, with the input stalled meanwhile. After reset
// a clearing pass fills the screen with blanks before the first word is accepted; configuration
// writes are taken at any time. One word is in flight at a time; a finished result waits in the
// output register while the next word is accepted, and that word's result is held back until
// the register frees.
module text_console_writer_core import tcw_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [7:0] char_code, [18:8] cell_index, [23:19] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  logic [CMD_W-1:0]       s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [10:0] cursor_pos, [18:11] cell_char, [26:19] cell_attr, [31:27] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  dp_cmd_t           dp_cmd;
  dp_stat_t          dp_stat;
  logic [CHAR_W-1:0] in_char;
  logic [INDEX_W-1:0] in_index;
  logic [POS_W-1:0]  cursor_pos;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;

  assign in_char     = s_axis_tdata[CHAR_W-1:0];
  assign in_index    = s_axis_tdata[CHAR_W+INDEX_W-1:CHAR_W];
  assign cfg_ready_o = 1'b1;

  tcw_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (cmd_e'(s_axis_tuser)),
    .in_char_i   (in_char),
    .out_ready_i (m_axis_tready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  tcw_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .char_code_i  (in_char),
    .cell_index_i (in_index),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .cursor_pos_o (cursor_pos),
    .cell_char_o  (cell_char),
    .cell_attr_o  (cell_attr)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - POS_W - CHAR_W - ATTR_W)'(0),
                         cell_attr, cell_char, cursor_pos};

`ifndef SYNTHESIS
  // one word at a time: an accepted word blocks the input on the next cycle
  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a word is in flight");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("waiting result word changed");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(m_axis_tdata[POS_W-1:0]) < CELL_COUNT))
    else $error("cursor position off screen");
`endif

endmodule

// ===== hdl/tcw_datapath.sv =====
// Screen memory, cursor, color registers, sweep counter and result register.
module tcw_datapath import tcw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  input  logic [CHAR_W-1:0]     char_code_i,
  input  logic [INDEX_W-1:0]    cell_index_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [POS_W-1:0]      cursor_pos_o,
  output logic [CHAR_W-1:0]     cell_char_o,
  output logic [ATTR_W-1:0]     cell_attr_o
);

  logic [CELL_W-1:0] screen_mem [CELL_COUNT];

  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [COLOR_W-1:0] fg_q, bg_q;
  logic [ADDR_W-1:0]  cnt_q;

  logic              wr_en_q;
  logic [ADDR_W-1:0] wr_addr_q;
  logic              wr_copy_q;
  logic              wr_rst_q;

  logic [CELL_W-1:0] rd_data_q;
  logic              rd_ok_q;

  logic              out_valid_q;
  logic [POS_W-1:0]  pos_q;
  logic [CHAR_W-1:0] char_q;
  logic [ATTR_W-1:0] attr_q;

  logic [ADDR_W-1:0] cur_lin;
  logic [31:0]       pos_ext;
  logic [ATTR_W-1:0] attr;
  logic [CELL_W-1:0] blank_cell;
  logic              col_last, row_last, at_origin, sweep_last, copy_now, idx_ok;
  logic              mem_we, rd_en;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [CELL_W-1:0] mem_wd;

  assign cur_lin    = ADDR_W'(32'(row_q) * SCREEN_WIDTH + 32'(col_q));
  assign pos_ext    = 32'(cur_lin);
  assign attr       = {bg_q, fg_q};
  assign blank_cell = {attr, BLANK_CODE};
  assign col_last   = (col_q == COL_W'(SCREEN_WIDTH - 1));
  assign row_last   = (row_q == ROW_W'(SCREEN_HEIGHT - 1));
  assign at_origin  = (row_q == '0) && (col_q == '0);
  assign sweep_last = (cnt_q == ADDR_W'(CELL_COUNT - 1));
  assign copy_now   = (cmd_i.sweep_kind == SW_SCROLL) && (32'(cnt_q) < COPY_COUNT);
  assign idx_ok     = (32'(cell_index_i) < CELL_COUNT);

  assign stat_o = '{col_last:   col_last,
                    row_last:   row_last,
                    at_origin:  at_origin,
                    sweep_last: sweep_last,
                    out_valid:  out_valid_q};

  // Sweep writes land in the cycle after their slot so a scroll copy can use the read data.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_lin;
    mem_wd = blank_cell;
    if (wr_en_q) begin
      mem_we = 1'b1;
      mem_wa = wr_addr_q;
      if (wr_copy_q) begin
        mem_wd = rd_data_q;
      end else if (wr_rst_q) begin
        mem_wd = RESET_CELL;
      end
    end else if (cmd_i.put_wr) begin
      mem_we = 1'b1;
      mem_wd = {attr, char_code_i};
    end else if (cmd_i.back_space && !at_origin) begin
      mem_we = 1'b1;
      mem_wa = cur_lin - 1'b1;
    end
  end

  always_comb begin
    rd_en  = cmd_i.sweep_en || cmd_i.rd_capture;
    mem_ra = '0;
    if (cmd_i.sweep_en) begin
      if (copy_now) begin
        mem_ra = ADDR_W'(32'(cnt_q) + SCREEN_WIDTH);
      end
    end else if (idx_ok) begin
      mem_ra = ADDR_W'(32'(cell_index_i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= screen_mem[mem_ra];
    end
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cmd_i.home) begin
      row_d = '0;
      col_d = '0;
    end else if (cmd_i.put_wr || cmd_i.new_line) begin
      if (cmd_i.new_line || col_last) begin
        col_d = '0;
        if (!row_last) begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end else if (cmd_i.back_space) begin
      if (col_q != '0) begin
        col_d = col_q - 1'b1;
      end else if (row_q != '0) begin
        row_d = row_q - 1'b1;
        col_d = COL_W'(SCREEN_WIDTH - 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      fg_q        <= FG_RESET;
      bg_q        <= BG_RESET;
      cnt_q       <= '0;
      wr_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      wr_en_q <= cmd_i.sweep_en;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_FOREGROUND) begin
          fg_q <= cfg_data_i[COLOR_W-1:0];
        end else if (cfg_index_i == REG_BACKGROUND) begin
          bg_q <= cfg_data_i[COLOR_W-1:0];
        end
      end
      if (cmd_i.sweep_en) begin
        cnt_q <= sweep_last ? '0 : cnt_q + 1'b1;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_en) begin
      wr_addr_q <= cnt_q;
      wr_copy_q <= copy_now;
      wr_rst_q  <= (cmd_i.sweep_kind == SW_RESET);
    end
    if (cmd_i.rd_capture) begin
      rd_ok_q <= idx_ok;
    end
    if (cmd_i.res_load) begin
      pos_q <= pos_ext[POS_W-1:0];
      if (cmd_i.res_rd && rd_ok_q) begin
        char_q <= rd_data_q[CHAR_W-1:0];
        attr_q <= rd_data_q[CELL_W-1:CHAR_W];
      end else begin
        char_q <= '0;
        attr_q <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = pos_q;
  assign cell_char_o  = char_q;
  assign cell_attr_o  = attr_q;

endmodule

// ===== hdl/tcw_controller.sv =====
// Command sequencer: decodes words, runs scroll/clear/reset sweeps, issues result loads.
module tcw_controller import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cmd_e              in_cmd_i,
  input  logic [CHAR_W-1:0] in_char_i,
  input  logic              out_ready_i,
  input  dp_stat_t          stat_i,
  output dp_cmd_t           cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DONE,
    ST_READ,
    ST_SWEEP,
    ST_FLUSH
  } state_e;

  state_e      state_q, state_d;
  sweep_kind_e kind_q, kind_d;
  logic        accept;
  logic        res_room;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // output register is free or empties at this edge
  assign res_room   = !stat_i.out_valid || out_ready_i;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    cmd_o.sweep_kind = kind_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DONE;
          case (in_cmd_i)
            CMD_PUT: begin
              if (in_char_i == NEWLINE_CODE) begin
                cmd_o.new_line = 1'b1;
                if (stat_i.row_last) begin
                  state_d = ST_SWEEP;
                  kind_d  = SW_SCROLL;
                end
              end else begin
                cmd_o.put_wr = 1'b1;
                if (stat_i.col_last && stat_i.row_last) begin
                  state_d = ST_SWEEP;
                  kind_d  = SW_SCROLL;
                end
              end
            end
            CMD_BS: begin
              cmd_o.back_space = 1'b1;
            end
            CMD_CLEAR: begin
              cmd_o.home = 1'b1;
              state_d    = ST_SWEEP;
              kind_d     = SW_CLEAR;
            end
            CMD_READ: begin
              cmd_o.rd_capture = 1'b1;
              state_d          = ST_READ;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_DONE: begin
        if (res_room) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_READ: begin
        if (res_room) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_rd   = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep_en = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // last sweep write retires as this state is entered; the power-on fill has no result
        if (kind_q == SW_RESET) begin
          state_d = ST_IDLE;
        end else if (res_room) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      kind_q  <= SW_RESET;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

// ===== tb/text_console_writer_core_tb.sv =====
// Self-checking testbench for the text console writer core: shadow screen model and stream checks.
`timescale 1ns / 100ps

module text_console_writer_core_tb;
  import tcw_pkg::*;

  typedef struct {
    cmd_e             cmd;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
  } console_cmd_t;

  // packed from the msb down, so a cast of the low result bits unpacks it
  typedef struct packed {
    logic [ATTR_W-1:0] cell_attr;
    logic [CHAR_W-1:0] cell_char;
    logic [POS_W-1:0]  cursor_pos;
  } cursor_result_t;

  typedef enum int {
    BURST_TEXT,
    BURST_NEWLINES,
    BURST_LONG_LINE,
    BURST_ERASE,
    BURST_READS,
    BURST_CLEAR,
    BURST_NOISE
  } burst_kind_e;

  localparam int RESULT_W = POS_W + CHAR_W + ATTR_W;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [7:0] char_code, [18:8] cell_index, [23:19] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // [1:0] cmd
  logic [CMD_W-1:0]       s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [10:0] cursor_pos, [18:11] cell_char, [26:19] cell_attr, [31:27] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  text_console_writer_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // shadow copy of the console
  logic [CELL_W-1:0]  screen_copy [CELL_COUNT];
  int                 cur_row = 0;
  int                 cur_col = 0;
  logic [COLOR_W-1:0] fg_color = FG_RESET;
  logic [COLOR_W-1:0] bg_color = BG_RESET;

  console_cmd_t   console_words_pending [$];
  cursor_result_t cursor_results_due [$];

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_len = 0;
  int   hold_seq = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   error_count = 0;
  logic in_fire = 1'b0;
  logic cfg_fire = 1'b0;

  console_cmd_t   drv_word;
  console_cmd_t   taken_word;
  cursor_result_t due_result;
  cursor_result_t seen_result;

  function automatic logic [CELL_W-1:0] blank_cell();
    return {bg_color, fg_color, BLANK_CODE};
  endfunction

  // cursor to start of next row, scrolling up one row past the bottom
  function automatic void next_row();
    cur_col = 0;
    if (cur_row == SCREEN_HEIGHT - 1) begin
      for (int i = 0; i < COPY_COUNT; i++) screen_copy[i] = screen_copy[i + SCREEN_WIDTH];
      for (int i = COPY_COUNT; i < CELL_COUNT; i++) screen_copy[i] = blank_cell();
    end else begin
      cur_row++;
    end
  endfunction

  function automatic cursor_result_t console_apply(console_cmd_t w);
    cursor_result_t r;
    r = '0;
    case (w.cmd)
      CMD_PUT: begin
        if (w.char_code == NEWLINE_CODE) begin
          next_row();
        end else begin
          screen_copy[cur_row * SCREEN_WIDTH + cur_col] = {bg_color, fg_color, w.char_code};
          if (cur_col == SCREEN_WIDTH - 1) next_row();
          else cur_col++;
        end
      end
      CMD_BS: begin
        // no-op at the origin; column zero wraps to the end of the row above
        if (cur_col > 0 || cur_row > 0) begin
          if (cur_col > 0) begin
            cur_col--;
          end else begin
            cur_row--;
            cur_col = SCREEN_WIDTH - 1;
          end
          screen_copy[cur_row * SCREEN_WIDTH + cur_col] = blank_cell();
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) screen_copy[i] = blank_cell();
        cur_row = 0;
        cur_col = 0;
      end
      CMD_READ: begin
        if (w.cell_index < CELL_COUNT) {r.cell_attr, r.cell_char} = screen_copy[w.cell_index];
      end
      default: ;
    endcase
    r.cursor_pos = POS_W'(cur_row * SCREEN_WIDTH + cur_col);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // result check, then prediction for the word taken at this edge
  always @(posedge clk_i) begin
    in_fire  <= s_axis_tvalid && s_axis_tready;
    cfg_fire <= cfg_valid_i && cfg_ready_o;
    if (m_axis_tvalid && m_axis_tready) begin
      seen_result = cursor_result_t'(m_axis_tdata[RESULT_W-1:0]);
      if (cursor_results_due.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        due_result = cursor_results_due.pop_front();
        check_field("cursor_pos", due_result.cursor_pos, seen_result.cursor_pos);
        check_field("cell_char", due_result.cell_char, seen_result.cell_char);
        check_field("cell_attr", due_result.cell_attr, seen_result.cell_attr);
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      taken_word.cmd        = cmd_e'(s_axis_tuser);
      taken_word.char_code  = s_axis_tdata[CHAR_W-1:0];
      taken_word.cell_index = s_axis_tdata[CHAR_W+INDEX_W-1:CHAR_W];
      cursor_results_due.push_back(console_apply(taken_word));
    end
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_FOREGROUND: fg_color = cfg_data_i[COLOR_W-1:0];
        REG_BACKGROUND: bg_color = cfg_data_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // input driver
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_fire) begin
      if (console_words_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_word = console_words_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= drv_word.cmd;
        s_axis_tdata  <= IN_TDATA_W'({drv_word.cell_index, drv_word.char_code});
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with an occasional long hold-off on request
  always @(negedge clk_i) begin
    if (hold_seen != hold_seq) begin
      hold_seen     <= hold_seq;
      hold_left     <= hold_len;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_word(input cmd_e c, input int ch, input int idx);
    console_cmd_t w;
    w.cmd        = c;
    w.char_code  = CHAR_W'(ch);
    w.cell_index = INDEX_W'(idx);
    console_words_pending.push_back(w);
  endtask

  task automatic queue_burst(input burst_kind_e kind);
    int n;
    int ch;
    int base;
    case (kind)
      BURST_TEXT: begin
        n = $urandom_range(40, 1);
        for (int i = 0; i < n; i++) begin
          ch = ($urandom_range(99) < 15) ? NEWLINE_CODE : $urandom_range(255);
          push_word(CMD_PUT, ch, $urandom_range(2047));
        end
      end
      BURST_NEWLINES: begin
        n = $urandom_range(30, 1);
        for (int i = 0; i < n; i++) push_word(CMD_PUT, NEWLINE_CODE, $urandom_range(2047));
      end
      BURST_LONG_LINE: begin
        // runs past the end of the row at least once
        n = $urandom_range(170, 80);
        for (int i = 0; i < n; i++) begin
          ch = $urandom_range(255);
          if (ch == NEWLINE_CODE) ch = BLANK_CODE;
          push_word(CMD_PUT, ch, $urandom_range(2047));
        end
      end
      BURST_ERASE: begin
        n = $urandom_range(90, 1);
        for (int i = 0; i < n; i++) push_word(CMD_BS, $urandom_range(255), $urandom_range(2047));
      end
      BURST_READS: begin
        n = $urandom_range(12, 1);
        base = $urandom_range(2047);
        for (int i = 0; i < n; i++) push_word(CMD_READ, $urandom_range(255), (base + i) & 11'h7FF);
      end
      BURST_CLEAR: push_word(CMD_CLEAR, $urandom_range(255), $urandom_range(2047));
      default: begin
        n = $urandom_range(10, 1);
        for (int i = 0; i < n; i++)
          push_word(cmd_e'($urandom_range(3)), $urandom_range(255), $urandom_range(2047));
      end
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(val);
    do @(negedge clk_i); while (!cfg_fire);
    cfg_valid_i <= 1'b0;
  endtask

  // checked at the rising edge, where the driver's outputs have settled
  task automatic wait_until_drained();
    while (console_words_pending.size() != 0 || s_axis_tvalid || cursor_results_due.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    int target;
    int pick;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    for (int i = 0; i < CELL_COUNT; i++) screen_copy[i] = RESET_CELL;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset contents, range edges, origin and column-zero backspace, clear
    push_word(CMD_READ, 8'h00, 0);
    push_word(CMD_READ, 8'hFF, CELL_COUNT - 1);
    push_word(CMD_READ, 8'h00, CELL_COUNT);
    push_word(CMD_READ, 8'hFF, 2047);
    push_word(CMD_BS, 8'hFF, 2047);
    push_word(CMD_PUT, 8'h41, 0);
    push_word(CMD_PUT, 8'h00, 2047);
    push_word(CMD_PUT, 8'hFF, 0);
    push_word(CMD_READ, 8'h00, 0);
    push_word(CMD_READ, 8'h00, 1);
    push_word(CMD_READ, 8'h00, 2);
    push_word(CMD_BS, 8'h00, 0);
    push_word(CMD_READ, 8'hFF, 2);
    push_word(CMD_PUT, NEWLINE_CODE, 0);
    push_word(CMD_BS, 8'h00, 0);
    push_word(CMD_READ, 8'h00, SCREEN_WIDTH - 1);
    push_word(CMD_PUT, 8'h7E, 0);
    push_word(CMD_READ, 8'h00, SCREEN_WIDTH - 1);
    push_word(CMD_CLEAR, 8'hFF, 2047);
    push_word(CMD_READ, 8'h00, 0);
    push_word(CMD_READ, 8'h00, SCREEN_WIDTH);
    wait_until_drained();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          fg = 4'h0; bg = 4'hF; send_idle_pct = 0; recv_stall_pct = 0;
        end
        1: begin
          fg = 4'hF; bg = 4'h0; send_idle_pct = 61; recv_stall_pct = 0;
        end
        2: begin
          fg = COLOR_W'($urandom_range(15)); bg = COLOR_W'($urandom_range(15));
          send_idle_pct = 0; recv_stall_pct = 61;
        end
        3: begin
          fg = 4'h0; bg = 4'h0; send_idle_pct = 38; recv_stall_pct = 38;
        end
        default: begin
          fg = 4'hF; bg = 4'hF; send_idle_pct = 0; recv_stall_pct = 0;
        end
      endcase
      write_reg(REG_FOREGROUND, fg);
      write_reg(REG_BACKGROUND, bg);
      if (p == 4) begin
        // receiver holds off while words keep coming, so the input backs up
        hold_len = 500;
        hold_seq++;
      end
      target = console_words_pending.size() + 120;
      if (p == 0) begin
        // make sure a scroll and an end-of-row wrap happen early
        queue_burst(BURST_NEWLINES);
        for (int i = 0; i < 26; i++) push_word(CMD_PUT, NEWLINE_CODE, $urandom_range(2047));
        queue_burst(BURST_LONG_LINE);
      end
      while (console_words_pending.size() < target) begin
        pick = $urandom_range(99);
        if (pick < 35) queue_burst(BURST_TEXT);
        else if (pick < 45) queue_burst(BURST_NEWLINES);
        else if (pick < 55) queue_burst(BURST_LONG_LINE);
        else if (pick < 67) queue_burst(BURST_ERASE);
        else if (pick < 92) queue_burst(BURST_READS);
        else if (pick < 95) queue_burst(BURST_CLEAR);
        else queue_burst(BURST_NOISE);
      end
      wait_until_drained();
    end

    repeat (50) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(64'd12_000_000 * 12);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
